[src/rcfr_pkg.sv]
// Shared types, constants and the CRC-8 step for the RC serial frame receiver.
// No dependencies; every other file of the block imports this package.
package rcfr_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 64;
	localparam int CHANNELS            = 16;
	localparam int CHANNEL_BITS        = 11;
	localparam int CHAN_IDX_W          = 4;
	localparam int PAYLOAD_BYTES       = 22;
	localparam int PAYLOAD_BITS        = PAYLOAD_BYTES * 8;
	localparam int HEADER_BYTES        = 3;
	localparam int HEADER_FRAME_SIZE   = 5;
	localparam int FRAME_SIZE_W        = 9;
	localparam int QUEUE_DEPTH         = 2;
	localparam int IN_TDATA_W          = 40;
	localparam int OUT_TDATA_W         = 16;
	localparam int CFG_DATA_W          = 16;

	localparam logic [7:0]  RC_FRAME_TYPE     = 8'h16;
	localparam logic [7:0]  RC_LENGTH_BYTE    = 8'd24;
	localparam logic [7:0]  CRC_POLY          = 8'hD5;
	localparam logic [15:0] TIMEOUT_RESET     = 16'd1100;
	localparam logic [7:0]  OWN_ADDRESS_RESET = 8'hC8;

	typedef enum logic [0:0] {
		REG_FRAME_TIMEOUT = 1'b0,
		REG_OWN_ADDRESS   = 1'b1
	} cfg_reg_t;

	typedef logic [PAYLOAD_BITS-1:0] payload_t;

	// Front to queue: one completed RC frame to unpack
	typedef struct packed {
		logic     push;
		payload_t payload;
	} frame_req_t;

	// Queue to back
	typedef struct packed {
		logic     empty;
		logic     full;
		payload_t head;
	} queue_stat_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

[src/rcfr_front.sv]
// Front end: byte intake, timeout, header capture, CRC and frame classification.
// Holds the configuration registers. Depends on rcfr_pkg.
module rcfr_front
	import rcfr_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  byte_valid,
	input  logic [7:0]            rx_byte,
	input  logic [31:0]           arrival_us,
	output frame_req_t            req
);

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	logic [15:0]             timeout_q;
	logic [7:0]              own_addr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [31:0]             start_q;
	logic [7:0]              crc_q;
	logic [7:0]              addr_q;
	logic [7:0]              len_q;
	logic [7:0]              type_q;
	payload_t                payload_q;

	logic [31:0]             elapsed;
	logic                    expired;
	logic [CNT_W-1:0]        cnt_eff;
	logic [FRAME_SIZE_W-1:0] pos;
	logic [FRAME_SIZE_W-1:0] frame_size;
	logic                    take;
	logic                    done;
	logic                    rc_ok;

	assign elapsed    = arrival_us - start_q;
	assign expired    = elapsed > {16'd0, timeout_q};
	assign cnt_eff    = expired ? '0 : cnt_q;
	assign pos        = FRAME_SIZE_W'(cnt_eff);
	assign frame_size = (pos < FRAME_SIZE_W'(HEADER_BYTES)) ? FRAME_SIZE_W'(HEADER_FRAME_SIZE)
		: ({1'b0, len_q} + FRAME_SIZE_W'(2));
	assign take       = (pos < frame_size) && (frame_size <= FRAME_SIZE_W'(MAX_FRAME_BYTES));
	assign done       = (pos + FRAME_SIZE_W'(1)) == frame_size;
	assign rc_ok      = (crc_q == rx_byte) && (type_q == RC_FRAME_TYPE)
		&& (addr_q == own_addr_q) && (len_q == RC_LENGTH_BYTE);

	assign req.push    = byte_valid && take && done && rc_ok;
	assign req.payload = payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RESET;
			own_addr_q <= OWN_ADDRESS_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_TIMEOUT: timeout_q  <= cfg_data;
				REG_OWN_ADDRESS:   own_addr_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			start_q <= '0;
			crc_q   <= '0;
		end else if (byte_valid) begin
			if (cnt_eff == '0) begin
				start_q <= arrival_us;
			end
			if (!take) begin
				// drop the byte, keep the count until the timeout restarts the frame
				cnt_q <= cnt_eff;
			end else if (done) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_eff + CNT_W'(1);
				if (pos == FRAME_SIZE_W'(2)) begin
					crc_q <= crc8_step(8'd0, rx_byte);
				end else if (pos > FRAME_SIZE_W'(2)) begin
					crc_q <= crc8_step(crc_q, rx_byte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && take && !done) begin
			if (pos == FRAME_SIZE_W'(0)) begin
				addr_q <= rx_byte;
			end
			if (pos == FRAME_SIZE_W'(1)) begin
				len_q <= rx_byte;
			end
			if (pos == FRAME_SIZE_W'(2)) begin
				type_q <= rx_byte;
			end
			// shift payload in from the top so the first byte lands in the low bits
			if (pos >= FRAME_SIZE_W'(HEADER_BYTES)
					&& pos < FRAME_SIZE_W'(HEADER_BYTES + PAYLOAD_BYTES)) begin
				payload_q <= {rx_byte, payload_q[PAYLOAD_BITS-1:8]};
			end
		end
	end

endmodule

[src/rcfr_queue.sv]
// Short queue of completed RC frame payloads between front and back.
// Depends on rcfr_pkg.
module rcfr_queue
	import rcfr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_req_t  req,
	input  logic        pop,
	output queue_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	payload_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.empty = count_q == '0;
	assign stat.full  = count_q == CNT_W'(DEPTH);
	assign stat.head  = mem_q[rd_ptr_q];
	assign do_push    = req.push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= req.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[src/rcfr_back.sv]
// Back end: unpacks one queued payload into 16 channel results, one per cycle unless
// the output is stalled, through a registered output stage. Depends on rcfr_pkg.
module rcfr_back
	import rcfr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  queue_stat_t             stat,
	output logic                    pop,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [CHAN_IDX_W-1:0]   out_index,
	output logic [CHANNEL_BITS-1:0] out_value,
	output logic                    out_last
);

	logic                  busy_q;
	logic [CHAN_IDX_W-1:0] ch_q;
	payload_t              sh_q;
	logic                  out_valid_q;
	logic                  advance;
	logic                  emit;
	logic                  final_ch;

	assign advance   = !out_valid_q || out_ready;
	assign emit      = advance && busy_q;
	assign final_ch  = ch_q == CHAN_IDX_W'(CHANNELS - 1);
	assign pop       = !busy_q && !stat.empty;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end else if (emit) begin
				ch_q <= ch_q + CHAN_IDX_W'(1);
				if (final_ch) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q <= stat.head;
		end else if (emit) begin
			sh_q <= sh_q >> CHANNEL_BITS;
		end
		if (emit) begin
			out_index <= ch_q;
			out_value <= sh_q[CHANNEL_BITS-1:0];
			out_last  <= final_ch;
		end
	end

endmodule

[src/rc_serial_frame_receiver.sv]
// RC serial frame receiver: one byte per cycle in, 16 channel results per good frame out.
// A good frame's CRC byte pushes its payload into the queue; the back end pops it when
// idle and sends one channel per cycle while m_axis_tready is high.
// Throughput: one byte per cycle; input stalls only while the two-entry frame queue is full.
// Reset (arst_n low): counters, CRC and queue cleared, timeout 1100 us, address 0xC8;
// no clearing pass, configuration writes are always ready.
module rc_serial_frame_receiver
	import rcfr_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // rx_byte[7:0], arrival_us[39:8]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // channel_index[3:0], channel_value[14:4], 0
	output logic                   m_axis_tlast,  // last_channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [0:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	frame_req_t                req;
	queue_stat_t               stat;
	logic                      pop;
	logic [CHAN_IDX_W-1:0]     ch_index;
	logic [CHANNEL_BITS-1:0]   ch_value;

	assign s_axis_tready = !stat.full;
	assign cfg_ready     = 1'b1;
	assign m_axis_tdata  = {1'b0, ch_value, ch_index};

	rcfr_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.byte_valid(s_axis_tvalid && s_axis_tready),
		.rx_byte   (s_axis_tdata[7:0]),
		.arrival_us(s_axis_tdata[39:8]),
		.req       (req)
	);

	rcfr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.pop   (pop),
		.stat  (stat)
	);

	rcfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.pop      (pop),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_index(ch_index),
		.out_value(ch_value),
		.out_last (m_axis_tlast)
	);

endmodule

[src/rcfr_checker.sv]
// Port-level checks on the channel result stream of the RC serial frame receiver.
// Depends on rcfr_pkg; bound to rc_serial_frame_receiver below.
module rcfr_port_checks
	import rcfr_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tlast
);

	// the final channel of a frame carries the top index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == CHAN_IDX_W'(CHANNELS - 1))
		else $error("tlast on a channel other than the last");

	// channels of one frame leave back to back in index order
	a_next_channel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid && m_axis_tdata[3:0] == CHAN_IDX_W'($past(m_axis_tdata[3:0]) + 4'd1))
		else $error("channel sequence broken");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

endmodule

bind rc_serial_frame_receiver rcfr_port_checks u_rcfr_checker (.*);

[tb/sv/rcfr_checker.sv]
// Scoreboard for the RC serial frame receiver: watches the byte, channel and config channels.
// Rebuilds frames from accepted bytes, predicts the channel results and compares them in order.
// Depends on rcfr_pkg for port widths and register names.
module rcfr_checker
	import rcfr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [0:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int unsigned            mismatches,
	output int unsigned            pending
);

	localparam int         FRAME_DEPTH = MAX_FRAME_BYTES_DEF;
	localparam int         N_CHANNELS  = 16;
	localparam int         CHAN_BITS   = 11;
	localparam int         PAYLOAD_LEN = 22;
	localparam int         HDR_LEN     = 3;
	localparam int         HDR_SIZE    = 5;
	localparam logic [7:0] CRC_POLY8   = 8'hD5;
	localparam logic [7:0] RC_TYPE     = 8'h16;
	localparam logic [7:0] RC_LEN      = 8'd24;

	typedef struct packed {
		logic [3:0]  index;
		logic [10:0] value;
		logic        last;
	} channel_t;

	channel_t    channel_q[$];
	logic [7:0]  frame_mem [FRAME_DEPTH];
	int unsigned held;
	logic [31:0] start_us;
	logic [7:0]  crc_acc;
	logic [15:0] timeout_us;
	logic [7:0]  address;

	function automatic logic [7:0] crc_dvb(input logic [7:0] crc, input logic [7:0] din);
		logic [7:0] r;
		r = crc ^ din;
		repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY8 : 8'h00);
		return r;
	endfunction

	task automatic take_byte(input logic [7:0] data, input logic [31:0] now);
		logic [31:0]                elapsed;
		int unsigned                size;
		int unsigned                pos;
		logic [8*PAYLOAD_LEN-1:0]   payload;
		channel_t                   res;
		elapsed = now - start_us;
		if (elapsed > {16'd0, timeout_us})
			held = 0;
		if (held == 0)
			start_us = now;
		size = (held < HDR_LEN) ? HDR_SIZE : int'(frame_mem[1]) + 2;
		// drop bytes while the length is unusable, until the timeout restarts the frame
		if (held >= size || size > FRAME_DEPTH)
			return;
		pos = held;
		frame_mem[pos] = data;
		held = pos + 1;
		if (held < size) begin
			if (pos == 2)
				crc_acc = crc_dvb(8'h00, data);
			else if (pos > 2)
				crc_acc = crc_dvb(crc_acc, data);
			return;
		end
		held = 0;
		if (crc_acc != data || frame_mem[2] != RC_TYPE || frame_mem[0] != address
				|| frame_mem[1] != RC_LEN)
			return;
		for (int i = 0; i < PAYLOAD_LEN; i++)
			payload[8*i +: 8] = frame_mem[HDR_LEN + i];
		for (int ch = 0; ch < N_CHANNELS; ch++) begin
			res.index = 4'(ch);
			res.value = payload[ch*CHAN_BITS +: CHAN_BITS];
			res.last  = (ch == N_CHANNELS - 1);
			channel_q.push_back(res);
		end
	endtask

	task automatic check_channel();
		channel_t got;
		channel_t want;
		got.index = m_axis_tdata[3:0];
		got.value = m_axis_tdata[14:4];
		got.last  = m_axis_tlast;
		if (channel_q.size() == 0) begin
			mismatches++;
			$display("%0t unexpected channel result: expected none, actual idx %0d value %0d last %0d",
				$time, got.index, got.value, got.last);
			return;
		end
		want = channel_q.pop_front();
		if (got != want) begin
			mismatches++;
			$display("%0t channel mismatch: expected idx %0d value %0d last %0d, actual idx %0d value %0d last %0d",
				$time, want.index, want.value, want.last, got.index, got.value, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q.delete();
			held       = 0;
			start_us   = '0;
			crc_acc    = '0;
			timeout_us = 16'd1100;
			address    = 8'hC8;
			mismatches = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_channel();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_TIMEOUT: timeout_us = cfg_data;
					REG_OWN_ADDRESS:   address = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				take_byte(s_axis_tdata[7:0], s_axis_tdata[39:8]);
		end
		pending = channel_q.size();
	end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the RC serial frame receiver: clock, reset, byte and register stimulus.
// Depends on rcfr_pkg, rc_serial_frame_receiver and rcfr_checker, which does all prediction.
module tb_top;
	import rcfr_pkg::*;

	localparam int         IDLE_PCT      = 15;
	localparam int         QUIET_LIMIT   = 2000;
	localparam int         SETTLE_CYCLES = 24;
	localparam logic [7:0] RC_TYPE       = 8'h16;
	localparam logic [7:0] RC_LEN        = 8'd24;

	typedef enum int {
		FR_GOOD, FR_BAD_CRC, FR_OTHER_ADDR, FR_OTHER_TYPE, FR_OTHER_LEN,
		FR_OVERSIZE, FR_UNDERSIZE, FR_TRUNCATED, FR_NOISE
	} frame_kind_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [0:0]             cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int unsigned            mismatches;
	int unsigned            pending;

	bit          idle_on = 1'b1;
	bit          need_gap = 1'b1;
	logic [31:0] now_us = '0;
	logic [15:0] cur_timeout = 16'd1100;
	logic [7:0]  cur_addr = 8'hC8;
	logic [7:0]  frame_q[$];
	int unsigned bytes_sent = 0;
	int unsigned channels_seen = 0;
	int unsigned quiet_cycles = 0;

	rc_serial_frame_receiver dut (.*);
	rcfr_checker chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk)
		m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);

	// Watchdog: end the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			channels_seen <= channels_seen + 1;
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("rc_serial_frame_receiver verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Leave tvalid high after the byte is taken; the next byte replaces it, an idle gap or a drain lowers it
	task automatic push_byte(input logic [7:0] data, input logic [31:0] at_us);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {at_us, data};
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [31:0] step);
		foreach (frame_q[i]) begin
			push_byte(frame_q[i], now_us);
			now_us += step;
		end
	endtask

	// Address, length, type, body, then CRC over type and body
	task automatic build_frame(input logic [7:0] addr, input logic [7:0] ftype,
			input logic [7:0] flen, input bit bad_crc, input bit split_fill);
		logic [7:0] crc;
		logic [7:0] body;
		frame_q = {addr, flen, ftype};
		crc = crc8_step(8'h00, ftype);
		for (int i = 0; i < int'(flen) - 2; i++) begin
			// split fill: channels 0..7 all zeros, 8..15 all ones
			body = split_fill ? ((i < 11) ? 8'h00 : 8'hFF) : 8'($urandom);
			frame_q.push_back(body);
			crc = crc8_step(crc, body);
		end
		if (bad_crc)
			crc ^= 8'h01 << $urandom_range(7);
		frame_q.push_back(crc);
	endtask

	task automatic random_frame();
		frame_kind_t kind;
		logic [7:0]  ftype;
		logic [7:0]  flen;
		logic [31:0] step;
		int unsigned n;
		kind = ($urandom_range(99) < 55) ? FR_GOOD
			: frame_kind_t'($urandom_range(FR_NOISE, FR_BAD_CRC));
		if (need_gap)
			now_us += {16'd0, cur_timeout} + 32'd1 + $urandom_range(400);
		else
			now_us += $urandom_range(300);
		if ($urandom_range(5) == 0)
			now_us = $urandom;
		if (cur_timeout == 0)
			step = 0;
		else
			step = $urandom_range((cur_timeout / 26 > 40) ? 40 : cur_timeout / 26);
		need_gap = 1'b1;
		case (kind)
			FR_GOOD, FR_BAD_CRC: begin
				build_frame(cur_addr, RC_TYPE, RC_LEN, kind == FR_BAD_CRC, 1'b0);
				need_gap = 1'b0;
			end
			FR_OTHER_ADDR: begin
				build_frame(cur_addr ^ 8'($urandom_range(255, 1)), RC_TYPE, RC_LEN, 1'b0, 1'b0);
				need_gap = 1'b0;
			end
			FR_OTHER_TYPE: begin
				ftype = 8'($urandom);
				if (ftype == RC_TYPE)
					ftype = ~ftype;
				build_frame(8'($urandom), ftype, 8'($urandom_range(30, 2)), 1'b0, 1'b0);
			end
			FR_OTHER_LEN: begin
				flen = 8'($urandom_range(62, 2));
				if (flen == RC_LEN)
					flen++;
				build_frame(cur_addr, RC_TYPE, flen, 1'($urandom_range(1)), 1'b0);
			end
			FR_OVERSIZE:
				frame_q = {cur_addr, 8'($urandom_range(255, 63)), RC_TYPE, 8'($urandom), 8'($urandom)};
			FR_UNDERSIZE:
				frame_q = {cur_addr, 8'($urandom_range(1)), RC_TYPE, 8'($urandom), 8'($urandom)};
			FR_TRUNCATED: begin
				build_frame(cur_addr, RC_TYPE, RC_LEN, 1'b0, 1'b0);
				n = $urandom_range(24, 1);
				frame_q = frame_q[0:n];
			end
			default: begin
				n = $urandom_range(8, 1);
				repeat (n) push_byte(8'($urandom), $urandom);
				frame_q.delete();
			end
		endcase
		send_frame(step);
	endtask

	task automatic run_phase(input int unsigned budget, input int unsigned want_channels);
		int unsigned stop_at;
		stop_at = bytes_sent + budget;
		need_gap = 1'b1;
		while (bytes_sent < stop_at || channels_seen < want_channels)
			random_frame();
	endtask

	// Hold the sender until every predicted channel is out, then let the block settle
	task automatic drain_channels();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FRAME_TIMEOUT)
			cur_timeout = value;
		else
			cur_addr = value[7:0];
		@(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Length byte 0 is too short: later bytes drop, even at exactly the timeout
		now_us = 32'hFFFF_FA00;
		frame_q = {cur_addr, 8'h00, RC_TYPE, 8'hFF};
		send_frame(32'd0);
		push_byte(8'h5A, now_us + 32'd1100);
		// One microsecond past the timeout restarts; last byte lands on the timeout, time wraps
		now_us += 32'd1101;
		build_frame(cur_addr, RC_TYPE, RC_LEN, 1'b0, 1'b1);
		send_frame(32'd44);

		run_phase(6, 0);
		drain_channels();
		write_reg(REG_FRAME_TIMEOUT, 16'hFFFF);
		write_reg(REG_OWN_ADDRESS, 16'h0000);
		run_phase(6, 0);
		drain_channels();

		// The sender never pauses and the sink is always ready through this phase
		idle_on = 1'b0;
		write_reg(REG_FRAME_TIMEOUT, 16'h0000);
		write_reg(REG_OWN_ADDRESS, 16'h00FF);
		run_phase(6, 0);
		drain_channels();

		idle_on = 1'b1;
		write_reg(REG_FRAME_TIMEOUT, 16'($urandom_range(2000, 300)));
		write_reg(REG_OWN_ADDRESS, 16'($urandom_range(255)));
		run_phase(6, 32);
		drain_channels();

		if (mismatches == 0 && pending == 0)
			$display("rc_serial_frame_receiver verification clean");
		else
			$display("rc_serial_frame_receiver verification failed");
		$finish;
	end

endmodule

[filelist.f]
src/rcfr_pkg.sv
src/rcfr_front.sv
src/rcfr_queue.sv
src/rcfr_back.sv
src/rc_serial_frame_receiver.sv
src/rcfr_checker.sv
tb/sv/rcfr_checker.sv
tb/sv/tb_top.sv
